>>> hw/rtl/bdte_pkg.sv
package bdte_pkg;

   // calendar constants
   localparam logic [11:0] BASE_YEAR      = 12'd1970;
   localparam logic [4:0]  MONTH_SHIFT    = 5'd2;
   localparam logic [4:0]  MONTHS         = 5'd12;
   localparam logic [8:0]  DAYS_PER_YEAR  = 9'd365;
   localparam logic [8:0]  MONTH_FACTOR   = 9'd367;
   localparam logic [31:0] DAY_OFFSET     = 32'd719499;
   localparam logic [4:0]  HOURS_PER_DAY  = 5'd24;
   localparam logic [5:0]  SIXTY          = 6'd60;

   // floor(x / 100) for x below 4096 as (x * RECIP_100) >> RECIP_SHIFT
   localparam logic [10:0] RECIP_100      = 11'd1311;
   // floor(x / 3) for x below 65536 as (x * RECIP_3) >> RECIP_SHIFT
   localparam logic [15:0] RECIP_3        = 16'd43691;
   localparam int          RECIP_SHIFT    = 17;

   // number of register stages from input to result
   localparam int          NUM_STAGES     = 7;

   // two bcd digits to binary, a non-decimal nibble keeps its weight
   function automatic logic [7:0] bcd_pair_value(input logic [7:0] b);
      logic [7:0] hi_times_ten;
      hi_times_ten = {1'b0, b[7:4], 3'b000} + {3'b000, b[7:4], 1'b0};
      return hi_times_ten + {4'b0000, b[3:0]};
   endfunction

endpackage

>>> hw/rtl/bcd_datetime_to_epoch_seconds.sv
// Converts one BCD real-time-clock snapshot (seconds, minutes, hours, day, month and years
// since 1970, two BCD digits each) into seconds since 1970-01-01 00:00:00 of the Gregorian
// calendar, using the day-count formula with March as the first month of the year. The block
// takes one word per cycle when no result-side stall holds the pipeline, through a 7-stage
// pipeline (decode, reciprocal multiplies for the divisions by 100, 400 and 12, day sum,
// then scaling by 24, 60 and 60). Inputs are not range checked: non-decimal nibbles
// keep their binary weight and results outside 32 bits wrap modulo 2^32. A stall on the
// result side holds the pipeline in place, and empty stages still fill while it stalls.
module bcd_datetime_to_epoch_seconds (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [6:0]  req_sec_bcd,
   input  logic [6:0]  req_min_bcd,
   input  logic [5:0]  req_hour_bcd,
   input  logic [5:0]  req_day_bcd,
   input  logic [4:0]  req_month_bcd,
   input  logic [7:0]  req_year_bcd,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_epoch_seconds
);
   import bdte_pkg::*;

   logic [NUM_STAGES-1:0] valid_ff, valid_in, load;

   // stage 1: bcd decode and month rotation
   logic [6:0]  s1_sec_ff, s1_min_ff;
   logic [5:0]  s1_hour_ff, s1_day_ff;
   logic [4:0]  s1_mon_ff;
   logic [11:0] s1_year_ff;
   logic [4:0]  dec_mon;
   logic [11:0] dec_year;

   // stage 2: year / 4, year / 100, 367 * month
   logic [6:0]  s2_sec_ff, s2_min_ff;
   logic [5:0]  s2_hour_ff, s2_day_ff;
   logic [11:0] s2_year_ff;
   logic [9:0]  s2_y4_ff;
   logic [4:0]  s2_y100_ff;
   logic [13:0] s2_m367_ff;
   logic [22:0] y100_prod;

   // stage 3: year / 400, month term, 365 * year, small partial sum
   logic [6:0]  s3_sec_ff, s3_min_ff;
   logic [5:0]  s3_hour_ff;
   logic [2:0]  s3_y400_ff;
   logic [9:0]  s3_mterm_ff;
   logic [19:0] s3_y365_ff;
   logic [9:0]  s3_part_ff;
   logic [20:0] y400_prod;
   logic [27:0] mterm_prod;

   // stage 4: day count
   logic [6:0]  s4_sec_ff, s4_min_ff;
   logic [5:0]  s4_hour_ff;
   logic [31:0] s4_days_ff;

   // stages 5 to 7: scaling to seconds
   logic [6:0]  s5_sec_ff, s5_min_ff;
   logic [31:0] s5_hours_ff;
   logic [6:0]  s6_sec_ff;
   logic [31:0] s6_mins_ff;
   logic [31:0] s7_total_ff;

   // a stage loads when it is empty or its word moves on
   always_comb begin
      load[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || !rsp_stall;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
      valid_in[0] = load[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         valid_in[k] = load[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall         = !load[0];
   assign rsp_valid         = valid_ff[NUM_STAGES-1];
   assign rsp_epoch_seconds = s7_total_ff;

   // january and february belong to the previous year
   always_comb begin
      logic [4:0] mon_bin;
      logic [11:0] year_bin;
      mon_bin  = 5'(bcd_pair_value(8'(req_month_bcd)));
      year_bin = 12'(bcd_pair_value(req_year_bcd)) + BASE_YEAR;
      if (mon_bin <= MONTH_SHIFT) begin
         dec_mon  = mon_bin + MONTHS - MONTH_SHIFT;
         dec_year = year_bin - 12'd1;
      end else begin
         dec_mon  = mon_bin - MONTH_SHIFT;
         dec_year = year_bin;
      end
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         s1_sec_ff  <= 7'(bcd_pair_value(8'(req_sec_bcd)));
         s1_min_ff  <= 7'(bcd_pair_value(8'(req_min_bcd)));
         s1_hour_ff <= 6'(bcd_pair_value(8'(req_hour_bcd)));
         s1_day_ff  <= 6'(bcd_pair_value(8'(req_day_bcd)));
         s1_mon_ff  <= dec_mon;
         s1_year_ff <= dec_year;
      end
   end

   assign y100_prod = 23'(s1_year_ff) * 23'(RECIP_100);

   always_ff @(posedge clock) begin
      if (load[1]) begin
         s2_sec_ff  <= s1_sec_ff;
         s2_min_ff  <= s1_min_ff;
         s2_hour_ff <= s1_hour_ff;
         s2_day_ff  <= s1_day_ff;
         s2_year_ff <= s1_year_ff;
         s2_y4_ff   <= s1_year_ff[11:2];
         s2_y100_ff <= 5'(y100_prod >> RECIP_SHIFT);
         s2_m367_ff <= 14'(s1_mon_ff) * 14'(MONTH_FACTOR);
      end
   end

   // year / 400 as (year / 4) / 100, month term as ((367 * month) / 4) / 3
   assign y400_prod  = 21'(s2_y4_ff) * 21'(RECIP_100);
   assign mterm_prod = 28'(s2_m367_ff[13:2]) * 28'(RECIP_3);

   always_ff @(posedge clock) begin
      if (load[2]) begin
         s3_sec_ff   <= s2_sec_ff;
         s3_min_ff   <= s2_min_ff;
         s3_hour_ff  <= s2_hour_ff;
         s3_y400_ff  <= 3'(y400_prod >> RECIP_SHIFT);
         s3_mterm_ff <= 10'(mterm_prod >> RECIP_SHIFT);
         s3_y365_ff  <= 20'(s2_year_ff) * 20'(DAYS_PER_YEAR);
         s3_part_ff  <= s2_y4_ff - 10'(s2_y100_ff) + 10'(s2_day_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (load[3]) begin
         s4_sec_ff  <= s3_sec_ff;
         s4_min_ff  <= s3_min_ff;
         s4_hour_ff <= s3_hour_ff;
         s4_days_ff <= 32'(s3_y365_ff) + 32'(s3_part_ff) + 32'(s3_y400_ff)
                       + 32'(s3_mterm_ff) - DAY_OFFSET;
      end
   end

   // all scaling wraps modulo 2^32
   always_ff @(posedge clock) begin
      if (load[4]) begin
         s5_sec_ff   <= s4_sec_ff;
         s5_min_ff   <= s4_min_ff;
         s5_hours_ff <= s4_days_ff * 32'(HOURS_PER_DAY) + 32'(s4_hour_ff);
      end
      if (load[5]) begin
         s6_sec_ff  <= s5_sec_ff;
         s6_mins_ff <= s5_hours_ff * 32'(SIXTY) + 32'(s5_min_ff);
      end
      if (load[6]) begin
         s7_total_ff <= s6_mins_ff * 32'(SIXTY) + 32'(s6_sec_ff);
      end
   end

endmodule

>>> sim/tb_bcd_datetime_to_epoch_seconds.sv
module tb_bcd_datetime_to_epoch_seconds;

   import bdte_pkg::*;

   localparam int QUIET_LIMIT   = 2000;
   localparam int HOLD_CYCLES   = 150;
   localparam int RANDOM_WORDS  = 350;

   typedef struct packed {
      logic [6:0] sec;
      logic [6:0] minute;
      logic [5:0] hour;
      logic [5:0] day;
      logic [4:0] month;
      logic [7:0] year;
   } snapshot_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [6:0]  req_sec_bcd;
   logic [6:0]  req_min_bcd;
   logic [5:0]  req_hour_bcd;
   logic [5:0]  req_day_bcd;
   logic [4:0]  req_month_bcd;
   logic [7:0]  req_year_bcd;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_epoch_seconds;

   logic [31:0] pending_epochs[$];
   int          errors      = 0;
   int          idle_pct    = 0;
   int          stall_pct   = 0;
   int          hold_asked  = 0;
   int          hold_served = 0;
   int          hold_left   = 0;

   bcd_datetime_to_epoch_seconds DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sec_bcd       (req_sec_bcd),
      .req_min_bcd       (req_min_bcd),
      .req_hour_bcd      (req_hour_bcd),
      .req_day_bcd       (req_day_bcd),
      .req_month_bcd     (req_month_bcd),
      .req_year_bcd      (req_year_bcd),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_epoch_seconds (rsp_epoch_seconds)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // nibbles weighted as they are, even above nine
   function automatic longint digit_pair(input logic [7:0] b);
      return longint'(b[7:4]) * 10 + longint'(b[3:0]);
   endfunction

   function automatic logic [31:0] epoch_of(input snapshot_type s);
      longint yr, mon, days, total;
      yr  = digit_pair(s.year) + 1970;
      mon = digit_pair({3'b000, s.month}) - 2;
      // march-based year: jan and feb belong to the year before
      if (mon <= 0) begin
         mon += 12;
         yr  -= 1;
      end
      days = yr / 4 - yr / 100 + yr / 400 + (367 * mon) / 12
             + digit_pair({2'b00, s.day}) + yr * 365 - 719499;
      total = ((days * 24 + digit_pair({2'b00, s.hour})) * 60
               + digit_pair({1'b0, s.minute})) * 60 + digit_pair({1'b0, s.sec});
      return total[31:0];
   endfunction

   function automatic logic [7:0] to_bcd(input int unsigned v);
      return {4'(v / 10), 4'(v % 10)};
   endfunction

   function automatic snapshot_type make_snapshot(input logic [7:0] sec, minute, hour, day,
                                                  month, year);
      snapshot_type s;
      s.sec    = sec[6:0];
      s.minute = minute[6:0];
      s.hour   = hour[5:0];
      s.day    = day[5:0];
      s.month  = month[4:0];
      s.year   = year;
      return s;
   endfunction

   function automatic snapshot_type random_snapshot();
      snapshot_type s;
      // mostly well-formed calendar values, the rest raw bits
      if ($urandom_range(99) < 85) begin
         s = make_snapshot(to_bcd($urandom_range(59)), to_bcd($urandom_range(59)),
                           to_bcd($urandom_range(23)), to_bcd($urandom_range(31, 1)),
                           to_bcd($urandom_range(12, 1)), to_bcd($urandom_range(99)));
      end else begin
         s = snapshot_type'(39'({$urandom, $urandom}));
      end
      return s;
   endfunction

   task automatic send_snapshot(input snapshot_type s);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sec_bcd   <= s.sec;
      req_min_bcd   <= s.minute;
      req_hour_bcd  <= s.hour;
      req_day_bcd   <= s.day;
      req_month_bcd <= s.month;
      req_year_bcd  <= s.year;
      do @(posedge clock); while (req_stall !== 1'b0);
      pending_epochs.push_back(epoch_of(s));
   endtask

   task automatic test_calendar_corners();
      send_snapshot(make_snapshot(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00));
      send_snapshot(make_snapshot(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99));
      send_snapshot(make_snapshot(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h29));
      // leap day of a year divisible by 400, then the day after
      send_snapshot(make_snapshot(8'h00, 8'h00, 8'h00, 8'h29, 8'h02, 8'h30));
      send_snapshot(make_snapshot(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h30));
      send_snapshot(make_snapshot(8'h00, 8'h00, 8'h00, 8'h28, 8'h02, 8'h01));
      send_snapshot(make_snapshot(8'h00, 8'h00, 8'h00, 8'h31, 8'h01, 8'h01));
      // century year that is not a leap year, reached with a non-decimal year digit
      send_snapshot(make_snapshot(8'h59, 8'h59, 8'h23, 8'h28, 8'h02, 8'hD0));
      send_snapshot(make_snapshot(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'hD0));
      // around the 32-bit wrap in early 2106
      send_snapshot(make_snapshot(8'h15, 8'h28, 8'h06, 8'h07, 8'h02, 8'hD6));
      send_snapshot(make_snapshot(8'h16, 8'h28, 8'h06, 8'h07, 8'h02, 8'hD6));
      // month zero and months past december
      send_snapshot(make_snapshot(8'h00, 8'h00, 8'h00, 8'h15, 8'h00, 8'h00));
      send_snapshot(make_snapshot(8'h00, 8'h00, 8'h00, 8'h01, 8'h13, 8'h50));
      send_snapshot(make_snapshot(8'h00, 8'h00, 8'h00, 8'h01, 8'h1F, 8'h50));
      // day zero, before the epoch
      send_snapshot(make_snapshot(8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00));
      send_snapshot(make_snapshot(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      send_snapshot(make_snapshot(8'h7F, 8'h7F, 8'h3F, 8'h3F, 8'h1F, 8'hFF));
      send_snapshot(make_snapshot(8'h0F, 8'h0F, 8'h0F, 8'h0F, 8'h0F, 8'h0F));
      send_snapshot(make_snapshot(8'h70, 8'h70, 8'h30, 8'h30, 8'h10, 8'hF0));
      send_snapshot(make_snapshot(8'h55, 8'h2A, 8'h15, 8'h2A, 8'h0A, 8'hAA));
      send_snapshot(make_snapshot(8'h2A, 8'h55, 8'h2A, 8'h15, 8'h15, 8'h55));
   endtask

   task automatic test_random_snapshots(input int sender_idle, input int receiver_stall);
      idle_pct  = sender_idle;
      stall_pct = receiver_stall;
      repeat (RANDOM_WORDS) send_snapshot(random_snapshot());
   endtask

   task automatic test_backpressure();
      idle_pct  = 0;
      stall_pct = 0;
      hold_asked++;
      // sender keeps offering while the result side is held off
      repeat (40) send_snapshot(random_snapshot());
   endtask

   // result-side stall, with a long hold-off on request
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_asked) begin
         hold_served <= hold_asked;
         hold_left   <= HOLD_CYCLES;
         rsp_stall   <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_epochs.size() == 0) begin
            errors++;
            $display("%0t: unexpected word, expected none, actual epoch_seconds %0d",
                     $time, rsp_epoch_seconds);
         end else if (rsp_epoch_seconds !== pending_epochs[0]) begin
            errors++;
            $display("%0t: epoch_seconds mismatch, expected %0d, actual %0d",
                     $time, pending_epochs[0], rsp_epoch_seconds);
            void'(pending_epochs.pop_front());
         end else begin
            void'(pending_epochs.pop_front());
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid === 1'b1 && req_stall === 1'b0) ||
             (rsp_valid === 1'b1 && rsp_stall === 1'b0))
            quiet = 0;
         else
            quiet++;
      end
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_sec_bcd   = '0;
      req_min_bcd   = '0;
      req_hour_bcd  = '0;
      req_day_bcd   = '0;
      req_month_bcd = '0;
      req_year_bcd  = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_calendar_corners();
      test_random_snapshots(0, 0);
      test_random_snapshots(49, 0);
      test_random_snapshots(0, 49);
      test_random_snapshots(29, 29);
      test_backpressure();

      req_valid <= 1'b0;
      while (pending_epochs.size() > 0) @(posedge clock);
      repeat (4 * NUM_STAGES) @(posedge clock);

      if (errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
